// ----- hdl/qapm_pkg.sv -----
// Shared types, widths and constants for the quad attitude PD mixer.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package qapm_pkg;

   // Field and datapath widths
   localparam int unsigned AngleW   = 16;
   localparam int unsigned ErrW     = AngleW + 1;   // setpoint - angle
   localparam int unsigned DiffW    = ErrW + 1;     // error - previous error
   localparam int unsigned GainW    = 16;
   localparam int unsigned KdScaleW = 22;          // 50 * kd fits in 22 bits unsigned
   localparam int unsigned PropW    = GainW + 1 + ErrW;      // signed kp * err
   localparam int unsigned DerivW   = KdScaleW + 1 + DiffW;  // signed 50*kd * diff
   localparam int unsigned SumW     = DerivW + 1;
   localparam int unsigned GainShift = 14;          // Q8.8 gain and 1/64 degree angle
   localparam int unsigned TermW    = 12;           // +/-1500
   localparam int unsigned DutyW    = 22;
   localparam int unsigned MixW     = DutyW + 2;    // signed throttle +/- mix
   localparam int unsigned AddrW    = 5;
   localparam int unsigned DataW    = 32;

   localparam int TermLimit  = 1500;
   localparam int MixFactor  = 250;

   // Register map, word index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_KP_GAIN       = 3'd0,
      REG_KD_GAIN       = 3'd1,
      REG_ROLL_SETPOINT = 3'd2,
      REG_PITCH_SETPOINT = 3'd3,
      REG_YAW_SETPOINT  = 3'd4,
      REG_BASE_THROTTLE = 3'd5,
      REG_MOTOR_MIN     = 3'd6,
      REG_MOTOR_MAX     = 3'd7
   } qapm_reg_type;

   typedef struct packed {
      logic signed [AngleW-1:0] roll_angle;
      logic signed [AngleW-1:0] pitch_angle;
      logic signed [AngleW-1:0] yaw_angle;
   } qapm_req_type;

   typedef struct packed {
      logic [DutyW-1:0] motor_one_duty;
      logic [DutyW-1:0] motor_two_duty;
      logic [DutyW-1:0] motor_three_duty;
      logic [DutyW-1:0] motor_four_duty;
   } qapm_rsp_type;

   typedef struct packed {
      logic [GainW-1:0]    kp_gain;
      logic [GainW-1:0]    kd_gain;
      logic [KdScaleW-1:0] kd_scaled;       // 50 * kd_gain, updated on write
      logic [AngleW-1:0]   roll_setpoint;
      logic [AngleW-1:0]   pitch_setpoint;
      logic [AngleW-1:0]   yaw_setpoint;
      logic [DutyW-1:0]    base_throttle;
      logic [DutyW-1:0]    motor_min;
      logic [DutyW-1:0]    motor_max;
   } qapm_cfg_type;

   localparam qapm_cfg_type CfgReset = '{
      kp_gain:        16'd5120,
      kd_gain:        16'd2048,
      kd_scaled:      22'd102400,
      roll_setpoint:  16'hFFE6,
      pitch_setpoint: 16'hFFED,
      yaw_setpoint:   16'd5728,
      base_throttle:  22'd1500000,
      motor_min:      22'd1000000,
      motor_max:      22'd2000000
   };

   // Per-stage load enables for the axis datapath
   typedef struct packed {
      logic accept;      // request taken into stage 1, previous error updates
      logic load_prod;   // stage 2: products
      logic load_term;   // stage 3: shifted, clamped term
   } qapm_pipe_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/quad_attitude_pd_mixer_core.sv -----
// Top level of the quad attitude PD controller with Quad-X motor mixer.
// Depends on qapm_pkg, qapm_regs, qapm_axis and qapm_mix.
//
// Use:
//  - req channel: one request is a roll/pitch/yaw sample (1/64 degree).
//    Taken when req_valid is high and req_stall is low.
//  - rsp channel: four motor duties per request, same order as requests.
//    Taken when rsp_valid is high and rsp_stall is low.
//  - csr port: APB-style, word registers at 4*index, pready tied high.
//    Write only while no request is in flight.
// Path: a taken request passes, in order, the error/diff register,
//   product register, term register and duty register to rsp_valid.
// Throughput: one request per cycle unless rsp_stall fills the 4-deep pipe.
// Stall: each stage refills as soon as the one after it empties, so the
//   pipe keeps taking requests until all four stages hold work; only then
//   does req_stall rise. The duty register holds its value while stalled.
// Reset (synchronous): registers return to defaults, the stored previous
//   errors clear to zero and the pipe empties.
`default_nettype none

module quad_attitude_pd_mixer_core
   import qapm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // request channel
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire qapm_req_type     req_data,
   // response channel
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output qapm_rsp_type          rsp_data,
   // configuration port
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [AddrW-1:0] csr_paddr,
   input  wire logic [DataW-1:0] csr_pwdata,
   output logic      [DataW-1:0] csr_prdata,
   output logic                  csr_pready
);

   qapm_cfg_type      cfg;
   qapm_pipe_ctl_type ctl;

   // stage valid flags: 1 = error/diff, 2 = products, 3 = terms
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic rsp_valid_ff, rsp_valid_in;
   qapm_rsp_type rsp_data_ff, duty;

   // a stage can load when it is empty or its content moves on
   logic rdy_out, rdy3, rdy2, rdy1;

   logic signed [TermW-1:0] roll_term, pitch_term, yaw_term;

   assign csr_pready = 1'b1;

   qapm_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   // ---- pipeline control ----
   assign rdy_out = ~rsp_valid_ff | ~rsp_stall;
   assign rdy3    = ~v3_ff | rdy_out;
   assign rdy2    = ~v2_ff | rdy3;
   assign rdy1    = ~v1_ff | rdy2;

   assign req_stall = ~rdy1;
   assign ctl       = '{accept: req_valid & rdy1, load_prod: rdy2, load_term: rdy3};

   assign v1_in        = rdy1    ? req_valid : v1_ff;
   assign v2_in        = rdy2    ? v1_ff     : v2_ff;
   assign v3_in        = rdy3    ? v2_ff     : v3_ff;
   assign rsp_valid_in = rdy_out ? v3_ff     : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- per-axis PD datapath ----
   qapm_axis u_axis_roll (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .angle     (req_data.roll_angle),
      .setpoint  (cfg.roll_setpoint),
      .kp_gain   (cfg.kp_gain),
      .kd_scaled (cfg.kd_scaled),
      .term      (roll_term)
   );

   qapm_axis u_axis_pitch (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .angle     (req_data.pitch_angle),
      .setpoint  (cfg.pitch_setpoint),
      .kp_gain   (cfg.kp_gain),
      .kd_scaled (cfg.kd_scaled),
      .term      (pitch_term)
   );

   qapm_axis u_axis_yaw (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .angle     (req_data.yaw_angle),
      .setpoint  (cfg.yaw_setpoint),
      .kp_gain   (cfg.kp_gain),
      .kd_scaled (cfg.kd_scaled),
      .term      (yaw_term)
   );

   // ---- mixer and duty register ----
   qapm_mix u_mix (
      .roll_term     (roll_term),
      .pitch_term    (pitch_term),
      .yaw_term      (yaw_term),
      .base_throttle (cfg.base_throttle),
      .motor_min     (cfg.motor_min),
      .motor_max     (cfg.motor_max),
      .duty          (duty)
   );

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         rsp_data_ff <= duty;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- assertions ----
   // input side stalls only when every stage holds a request
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("req_stall with a free pipeline stage");

   // a request taken moves into stage 1
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      ctl.accept |=> v1_ff)
      else $error("accepted request lost at stage 1");

   // stalled stage 3 work stays put
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !rdy3) |=> v3_ff)
      else $error("stage 3 dropped a held request");

   // motor one and motor four duties honor the limits when they do not conflict
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cfg.motor_max >= cfg.motor_min)) |->
      (rsp_data.motor_one_duty   <= cfg.motor_max && rsp_data.motor_one_duty   >= cfg.motor_min &&
       rsp_data.motor_four_duty  <= cfg.motor_max && rsp_data.motor_four_duty  >= cfg.motor_min))
      else $error("motor duty outside limits");

   // conflicting limits: minimum wins on every motor
   a_duty_conflict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cfg.motor_max < cfg.motor_min)) |->
      (rsp_data.motor_one_duty == cfg.motor_min && rsp_data.motor_two_duty == cfg.motor_min &&
       rsp_data.motor_three_duty == cfg.motor_min && rsp_data.motor_four_duty == cfg.motor_min))
      else $error("conflicting limits did not yield motor_min");

endmodule

`default_nettype wire

// ----- hdl/qapm_regs.sv -----
// Configuration register file with APB-style write and read.
// Depends on qapm_pkg.
`default_nettype none

module qapm_regs
   import qapm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [AddrW-1:0] csr_paddr,
   input  wire logic [DataW-1:0] csr_pwdata,
   output logic      [DataW-1:0] csr_prdata,
   output qapm_cfg_type          cfg
);

   qapm_cfg_type      cfg_ff, cfg_in;
   qapm_reg_type      reg_sel;
   logic              wr_en;
   logic [GainW-1:0]  wdata16;
   logic [KdScaleW-1:0] kd_scaled_wr;

   assign reg_sel = qapm_reg_type'(csr_paddr[AddrW-1:2]);
   assign wr_en   = csr_psel & csr_penable & csr_pwrite;
   assign wdata16 = csr_pwdata[GainW-1:0];

   // 50 = 32 + 16 + 2
   assign kd_scaled_wr = KdScaleW'({wdata16, 5'b0}) + KdScaleW'({wdata16, 4'b0})
                       + KdScaleW'({wdata16, 1'b0});

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_KP_GAIN:        cfg_in.kp_gain = wdata16;
            REG_KD_GAIN: begin
               cfg_in.kd_gain   = wdata16;
               cfg_in.kd_scaled = kd_scaled_wr;
            end
            REG_ROLL_SETPOINT:  cfg_in.roll_setpoint  = wdata16;
            REG_PITCH_SETPOINT: cfg_in.pitch_setpoint = wdata16;
            REG_YAW_SETPOINT:   cfg_in.yaw_setpoint   = wdata16;
            REG_BASE_THROTTLE:  cfg_in.base_throttle  = csr_pwdata[DutyW-1:0];
            REG_MOTOR_MIN:      cfg_in.motor_min      = csr_pwdata[DutyW-1:0];
            REG_MOTOR_MAX:      cfg_in.motor_max      = csr_pwdata[DutyW-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_KP_GAIN:        csr_prdata = DataW'(cfg_ff.kp_gain);
         REG_KD_GAIN:        csr_prdata = DataW'(cfg_ff.kd_gain);
         REG_ROLL_SETPOINT:  csr_prdata = DataW'(cfg_ff.roll_setpoint);
         REG_PITCH_SETPOINT: csr_prdata = DataW'(cfg_ff.pitch_setpoint);
         REG_YAW_SETPOINT:   csr_prdata = DataW'(cfg_ff.yaw_setpoint);
         REG_BASE_THROTTLE:  csr_prdata = DataW'(cfg_ff.base_throttle);
         REG_MOTOR_MIN:      csr_prdata = DataW'(cfg_ff.motor_min);
         REG_MOTOR_MAX:      csr_prdata = DataW'(cfg_ff.motor_max);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/qapm_axis.sv -----
// One axis of the PD controller: error, products, shift and clamp in three stages.
// Depends on qapm_pkg; load enables come from the top level.
`default_nettype none

module qapm_axis
   import qapm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire qapm_pipe_ctl_type        ctl,
   input  wire logic signed [AngleW-1:0] angle,
   input  wire logic        [AngleW-1:0] setpoint,
   input  wire logic        [GainW-1:0]  kp_gain,
   input  wire logic     [KdScaleW-1:0]  kd_scaled,
   output logic signed      [TermW-1:0]  term
);

   // Stage 1: err_ff is also the previous error for the next request
   logic signed [ErrW-1:0]   err_ff, err_in;
   logic signed [DiffW-1:0]  diff_ff, diff_in;
   // Stage 2
   logic signed [PropW-1:0]  prop_ff, prop_in;
   logic signed [DerivW-1:0] deriv_ff, deriv_in;
   // Stage 3
   logic signed [TermW-1:0]  term_ff, term_in;

   logic signed [SumW-1:0]   pd_sum;
   logic signed [SumW-1:0]   pd_biased;
   logic signed [SumW-1:0]   pd_shift;

   assign err_in  = $signed({setpoint[AngleW-1], setpoint}) - $signed({angle[AngleW-1], angle});
   assign diff_in = $signed({err_in[ErrW-1], err_in}) - $signed({err_ff[ErrW-1], err_ff});

   assign prop_in  = $signed({1'b0, kp_gain}) * err_ff;
   assign deriv_in = $signed({1'b0, kd_scaled}) * diff_ff;

   // Truncate toward zero: bias negatives before the arithmetic shift
   assign pd_sum    = prop_ff - deriv_ff;
   assign pd_biased = pd_sum + (pd_sum[SumW-1] ? SumW'((1 << GainShift) - 1) : '0);
   assign pd_shift  = pd_biased >>> GainShift;

   always_comb begin
      if (pd_shift > SumW'(TermLimit)) begin
         term_in = TermW'(TermLimit);
      end else if (pd_shift < -SumW'(TermLimit)) begin
         term_in = -TermW'(TermLimit);
      end else begin
         term_in = pd_shift[TermW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
      end else if (ctl.accept) begin
         err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         diff_ff <= diff_in;
      end
      if (ctl.load_prod) begin
         prop_ff  <= prop_in;
         deriv_ff <= deriv_in;
      end
      if (ctl.load_term) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

`default_nettype wire

// ----- hdl/qapm_mix.sv -----
// Quad-X motor mixer: three axis terms into four clamped duties.
// Depends on qapm_pkg; purely combinational, registered by the top level.
`default_nettype none

module qapm_mix
   import qapm_pkg::*;
(
   input  wire logic signed [TermW-1:0] roll_term,
   input  wire logic signed [TermW-1:0] pitch_term,
   input  wire logic signed [TermW-1:0] yaw_term,
   input  wire logic        [DutyW-1:0] base_throttle,
   input  wire logic        [DutyW-1:0] motor_min,
   input  wire logic        [DutyW-1:0] motor_max,
   output qapm_rsp_type                 duty
);

   logic signed [TermW:0]  sum_a, sum_b;
   logic signed [MixW-1:0] mix_a, mix_b, thr;

   function automatic logic [DutyW-1:0] limit_duty(
      input logic signed [MixW-1:0] v,
      input logic        [DutyW-1:0] mx,
      input logic        [DutyW-1:0] mn
   );
      logic signed [MixW-1:0] r;
      r = v;
      if (r > $signed({2'b00, mx})) r = $signed({2'b00, mx});
      if (r < $signed({2'b00, mn})) r = $signed({2'b00, mn});   // min wins
      return r[DutyW-1:0];
   endfunction

   assign sum_a = $signed({pitch_term[TermW-1], pitch_term}) + $signed({yaw_term[TermW-1], yaw_term});
   assign sum_b = $signed({roll_term[TermW-1], roll_term}) - $signed({yaw_term[TermW-1], yaw_term});
   assign mix_a = sum_a * $signed(MixW'(MixFactor));
   assign mix_b = sum_b * $signed(MixW'(MixFactor));
   assign thr   = $signed({2'b00, base_throttle});

   assign duty.motor_one_duty   = limit_duty(thr + mix_a, motor_max, motor_min);
   assign duty.motor_two_duty   = limit_duty(thr - mix_a, motor_max, motor_min);
   assign duty.motor_three_duty = limit_duty(thr + mix_b, motor_max, motor_min);
   assign duty.motor_four_duty  = limit_duty(thr - mix_b, motor_max, motor_min);

endmodule

`default_nettype wire

// ----- test/quad_attitude_pd_mixer_core_tb.sv -----
// Self-checking bench for quad_attitude_pd_mixer_core: a directed table, then
// random attitude samples under several gain/limit settings, scored against an
// in-bench PD/mixer predictor or hand-typed duties. Depends on qapm_pkg and hdl/.

module quad_attitude_pd_mixer_core_tb;
   import qapm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint RateFactor   = 50;       // kd is per 0.02 s period
   localparam int     DrainCycles  = 8;        // pipe is four stages deep
   localparam int     LongHold     = 120;      // long receiver hold-off
   localparam int     PhaseCount   = 8;
   localparam int     ItemsPerPhase = 250;
   localparam int     CycleLimit   = 1000000;

   // One row of the directed table: a register write or a request,
   // optionally with the motor duties spelled out by hand.
   typedef struct {
      bit           is_write;
      qapm_reg_type csr_index;
      logic [31:0]  wdata;
      qapm_req_type sample;
      bit           pinned;
      qapm_rsp_type want;
   } dir_step_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   qapm_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   qapm_rsp_type rsp_data;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [AddrW-1:0] csr_paddr = '0;
   logic [DataW-1:0] csr_pwdata = '0;
   logic [DataW-1:0] csr_prdata;
   logic         csr_pready;

   // Shadow copy of the register file, as the datapath sees it
   longint cfg_kp       = 5120;
   longint cfg_kd       = 2048;
   longint cfg_roll_sp  = -26;
   longint cfg_pitch_sp = -19;
   longint cfg_yaw_sp   = 5728;
   longint cfg_base     = 1500000;
   longint cfg_min      = 1000000;
   longint cfg_max      = 2000000;

   // Stored errors of the last request, zero at start like the DUT's after reset
   longint last_roll_err  = 0;
   longint last_pitch_err = 0;
   longint last_yaw_err   = 0;

   qapm_rsp_type duty_expect_q[$];
   qapm_rsp_type pinned_duties[int];   // hand-typed duties, keyed by request index
   int sent_count     = 0;             // requests accepted, counted by the sender
   int taken_count    = 0;             // requests accepted, counted by the monitor
   int rsp_count      = 0;
   int mismatch_count = 0;
   int hold_ask       = 0;             // bumped to ask the receiver for a long hold

   quad_attitude_pd_mixer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the pipe hangs
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   // PD term of one axis: kp*e - 50*kd*(e - e_last), over 2^14, toward zero,
   // then clamped to the term limit.
   function automatic longint pd_term(input longint err, input longint last_err);
      longint t;
      t = (cfg_kp * err - RateFactor * cfg_kd * (err - last_err))
          / (longint'(1) << GainShift);
      if (t > TermLimit) t = TermLimit;
      if (t < -TermLimit) t = -TermLimit;
      return t;
   endfunction

   // Upper limit first, lower limit last: min wins when the two conflict
   function automatic logic [DutyW-1:0] limit_duty(input longint v);
      if (v > cfg_max) v = cfg_max;
      if (v < cfg_min) v = cfg_min;
      return v[DutyW-1:0];
   endfunction

   function automatic qapm_rsp_type predict_motor_duties(input qapm_req_type s);
      longint e_roll, e_pitch, e_yaw;
      longint t_roll, t_pitch, t_yaw;
      longint mix_a, mix_b;
      qapm_rsp_type duty;
      e_roll  = cfg_roll_sp  - longint'(s.roll_angle);
      e_pitch = cfg_pitch_sp - longint'(s.pitch_angle);
      e_yaw   = cfg_yaw_sp   - longint'(s.yaw_angle);
      t_roll  = pd_term(e_roll,  last_roll_err);
      t_pitch = pd_term(e_pitch, last_pitch_err);
      t_yaw   = pd_term(e_yaw,   last_yaw_err);
      last_roll_err  = e_roll;
      last_pitch_err = e_pitch;
      last_yaw_err   = e_yaw;
      // Quad-X mix: pitch+yaw on motors one/two, roll-yaw on three/four
      mix_a = (t_pitch + t_yaw) * MixFactor;
      mix_b = (t_roll - t_yaw) * MixFactor;
      duty.motor_one_duty   = limit_duty(cfg_base + mix_a);
      duty.motor_two_duty   = limit_duty(cfg_base - mix_a);
      duty.motor_three_duty = limit_duty(cfg_base + mix_b);
      duty.motor_four_duty  = limit_duty(cfg_base - mix_b);
      return duty;
   endfunction

   // ---------------------------------------------------------------- scoring

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("[%0t] response %0d: %s got %0d expected %0d",
               $time, rsp_count, what, got, want);
      mismatch_count++;
   endtask

   // Requests are predicted the moment they are taken; responses are matched
   // in order against the oldest prediction.
   always @(posedge clock) begin : duty_monitor
      qapm_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            want = predict_motor_duties(req_data);
            if (pinned_duties.exists(taken_count)) want = pinned_duties[taken_count];
            duty_expect_q.push_back(want);
            taken_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (duty_expect_q.size() == 0) begin
               report_mismatch("response with no request pending", 0, 0);
            end else begin
               want = duty_expect_q.pop_front();
               if (rsp_data.motor_one_duty !== want.motor_one_duty)
                  report_mismatch("motor_one_duty", rsp_data.motor_one_duty,
                                  want.motor_one_duty);
               if (rsp_data.motor_two_duty !== want.motor_two_duty)
                  report_mismatch("motor_two_duty", rsp_data.motor_two_duty,
                                  want.motor_two_duty);
               if (rsp_data.motor_three_duty !== want.motor_three_duty)
                  report_mismatch("motor_three_duty", rsp_data.motor_three_duty,
                                  want.motor_three_duty);
               if (rsp_data.motor_four_duty !== want.motor_four_duty)
                  report_mismatch("motor_four_duty", rsp_data.motor_four_duty,
                                  want.motor_four_duty);
            end
            rsp_count++;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // Random stall runs, short ones mostly, plus long holds on request from
   // the stimulus so the pipe fills and backs up into req_stall.
   initial begin : rsp_stall_gen
      int pick, span_left, hold_left, holds_served;
      span_left = 0;
      hold_left = 0;
      holds_served = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_ask != holds_served) begin
            holds_served++;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (span_left > 0) begin
            span_left--;
         end else begin
            pick = $urandom_range(0, 99);
            rsp_stall <= (pick >= 55);
            if (pick < 45) span_left = $urandom_range(0, 7);
            else if (pick < 55) span_left = $urandom_range(20, 80);
            else if (pick < 92) span_left = $urandom_range(0, 2);
            else span_left = $urandom_range(8, 30);
         end
      end
   end

   // ---------------------------------------------------------------- sender

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Walk around the last angle, land near the setpoint, or go anywhere
   function automatic int pick_angle(input longint aim, input int last);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return last + int'($urandom_range(0, 200)) - 100;
      if (pick < 7) return int'(aim) + int'($urandom_range(0, 800)) - 400;
      return $urandom;
   endfunction

   // valid stays up between back-to-back requests; lowered here only for a gap
   task automatic send_request(input qapm_req_type sample, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Registers may only change with the pipe empty
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (rsp_count < sent_count) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Setup phase, then access phase; the write lands on the access edge.
   // The bus then returns to idle before the task ends.
   task automatic csr_write(input qapm_reg_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // Only the register's own width is kept
      case (idx)
         REG_KP_GAIN:        cfg_kp       = longint'(value[GainW-1:0]);
         REG_KD_GAIN:        cfg_kd       = longint'(value[GainW-1:0]);
         REG_ROLL_SETPOINT:  cfg_roll_sp  = longint'(signed'(value[AngleW-1:0]));
         REG_PITCH_SETPOINT: cfg_pitch_sp = longint'(signed'(value[AngleW-1:0]));
         REG_YAW_SETPOINT:   cfg_yaw_sp   = longint'(signed'(value[AngleW-1:0]));
         REG_BASE_THROTTLE:  cfg_base     = longint'(value[DutyW-1:0]);
         REG_MOTOR_MIN:      cfg_min      = longint'(value[DutyW-1:0]);
         REG_MOTOR_MAX:      cfg_max      = longint'(value[DutyW-1:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- directed rows

   function automatic dir_step_type row_wr(input qapm_reg_type idx, input logic [31:0] v);
      dir_step_type r;
      r = '{csr_index: REG_KP_GAIN, default: '0};
      r.is_write  = 1'b1;
      r.csr_index = idx;
      r.wdata     = v;
      return r;
   endfunction

   function automatic dir_step_type row_req(input int roll, input int pitch, input int yaw);
      dir_step_type r;
      r = '{csr_index: REG_KP_GAIN, default: '0};
      r.csr_index          = REG_KP_GAIN;
      r.sample.roll_angle  = roll[AngleW-1:0];
      r.sample.pitch_angle = pitch[AngleW-1:0];
      r.sample.yaw_angle   = yaw[AngleW-1:0];
      return r;
   endfunction

   function automatic dir_step_type row_chk(input int roll, input int pitch, input int yaw,
                                            input int d1, input int d2,
                                            input int d3, input int d4);
      dir_step_type r;
      r = row_req(roll, pitch, yaw);
      r.pinned                = 1'b1;
      r.want.motor_one_duty   = d1[DutyW-1:0];
      r.want.motor_two_duty   = d2[DutyW-1:0];
      r.want.motor_three_duty = d3[DutyW-1:0];
      r.want.motor_four_duty  = d4[DutyW-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      dir_step_type steps[$];
      qapm_req_type sample;
      int phase, n;
      int roll_walk, pitch_walk, yaw_walk;
      bit pressure;

      roll_walk  = -26;
      pitch_walk = -19;
      yaw_walk   = 5728;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // At reset values, angles on the setpoints give zero error: base duty
      steps.push_back(row_chk(-26, -19, 5728, 1500000, 1500000, 1500000, 1500000));
      steps.push_back(row_chk(-26, -19, 5728, 1500000, 1500000, 1500000, 1500000));
      // Full-scale angles with the default gains
      steps.push_back(row_req(-32768, 32767, -32768));
      steps.push_back(row_req(32767, -32768, 32767));
      steps.push_back(row_req(0, 0, 0));
      // Pure P at maximum gain: every term saturates, mix of +/-750000
      steps.push_back(row_wr(REG_KD_GAIN, 32'd0));
      steps.push_back(row_wr(REG_KP_GAIN, 32'd65535));
      steps.push_back(row_chk(-32768, 32767, 32767, 1000000, 2000000, 2000000, 1000000));
      // Limits and throttle above the nominal range, mix computed wide
      steps.push_back(row_wr(REG_MOTOR_MAX, 32'h003F_FFFF));
      steps.push_back(row_wr(REG_MOTOR_MIN, 32'd0));
      steps.push_back(row_wr(REG_BASE_THROTTLE, 32'h003F_FFFF));
      steps.push_back(row_chk(-32768, 32767, 32767, 3444303, 4194303, 4194303, 3444303));
      // Zero throttle: negative mix clamps at zero
      steps.push_back(row_wr(REG_BASE_THROTTLE, 32'd0));
      steps.push_back(row_chk(-32768, 32767, 32767, 0, 750000, 750000, 0));
      // Limits in conflict: min wins on every motor
      steps.push_back(row_wr(REG_MOTOR_MIN, 32'd3000000));
      steps.push_back(row_wr(REG_MOTOR_MAX, 32'd100));
      steps.push_back(row_chk(1234, -4321, 77, 3000000, 3000000, 3000000, 3000000));
      // Bits above each register's width are dropped
      steps.push_back(row_wr(REG_KP_GAIN, 32'hFFFF_0000));
      steps.push_back(row_wr(REG_KD_GAIN, 32'hABCD_0000));
      steps.push_back(row_wr(REG_MOTOR_MIN, 32'hFFC0_0000));
      steps.push_back(row_wr(REG_MOTOR_MAX, 32'hFFFF_FFFF));
      steps.push_back(row_wr(REG_BASE_THROTTLE, 32'h8012_3456));
      steps.push_back(row_chk(-32768, -32768, -32768, 1193046, 1193046, 1193046, 1193046));
      // Setpoints at the extremes, kp of 1.0 and kd of one LSB, largest errors and jumps
      steps.push_back(row_wr(REG_ROLL_SETPOINT, 32'h1234_8000));
      steps.push_back(row_wr(REG_PITCH_SETPOINT, 32'h0000_7FFF));
      steps.push_back(row_wr(REG_YAW_SETPOINT, 32'hFFFF_8000));
      steps.push_back(row_wr(REG_KP_GAIN, 32'd256));
      steps.push_back(row_wr(REG_KD_GAIN, 32'd1));
      steps.push_back(row_req(32767, -32768, 32767));
      steps.push_back(row_req(-32768, 32767, -32768));
      steps.push_back(row_req(100, -100, 0));
      steps.push_back(row_req(-1, 1, -1));

      foreach (steps[i]) begin
         if (steps[i].is_write) begin
            drain_pipe();
            csr_write(steps[i].csr_index, steps[i].wdata);
         end else begin
            if (steps[i].pinned) pinned_duties[sent_count] = steps[i].want;
            send_request(steps[i].sample, pick_gap());
         end
      end

      // Random part: each phase reprograms every register, then streams
      // samples. Phases 0..2 are fixed settings (reset values, all-max,
      // zero/minimum), the rest are random.
      for (phase = 0; phase < PhaseCount; phase++) begin
         drain_pipe();
         case (phase)
            0: begin
               csr_write(REG_KP_GAIN, 32'd5120);
               csr_write(REG_KD_GAIN, 32'd2048);
               csr_write(REG_ROLL_SETPOINT, 32'hFFFF_FFE6);
               csr_write(REG_PITCH_SETPOINT, 32'hFFFF_FFED);
               csr_write(REG_YAW_SETPOINT, 32'd5728);
               csr_write(REG_BASE_THROTTLE, 32'd1500000);
               csr_write(REG_MOTOR_MIN, 32'd1000000);
               csr_write(REG_MOTOR_MAX, 32'd2000000);
            end
            1: begin
               csr_write(REG_KP_GAIN, 32'd65535);
               csr_write(REG_KD_GAIN, 32'd65535);
               csr_write(REG_ROLL_SETPOINT, 32'h0000_7FFF);
               csr_write(REG_PITCH_SETPOINT, 32'h0000_8000);
               csr_write(REG_YAW_SETPOINT, 32'd0);
               csr_write(REG_BASE_THROTTLE, 32'h003F_FFFF);
               csr_write(REG_MOTOR_MIN, 32'd0);
               csr_write(REG_MOTOR_MAX, 32'h003F_FFFF);
            end
            2: begin
               csr_write(REG_KP_GAIN, 32'd0);
               csr_write(REG_KD_GAIN, 32'd65535);
               csr_write(REG_ROLL_SETPOINT, 32'h0000_8000);
               csr_write(REG_PITCH_SETPOINT, 32'h0000_8000);
               csr_write(REG_YAW_SETPOINT, 32'h0000_8000);
               csr_write(REG_BASE_THROTTLE, 32'd0);
               csr_write(REG_MOTOR_MIN, 32'd0);
               csr_write(REG_MOTOR_MAX, 32'd4000000);
            end
            default: begin
               // Mostly gains that keep terms out of saturation, sometimes
               // anything the bus can carry
               csr_write(REG_KP_GAIN, ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 8191));
               csr_write(REG_KD_GAIN, ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 1023));
               csr_write(REG_ROLL_SETPOINT, ($urandom_range(0, 1) == 0) ? $urandom
                         : $urandom_range(0, 4000) - 2000);
               csr_write(REG_PITCH_SETPOINT, ($urandom_range(0, 1) == 0) ? $urandom
                         : $urandom_range(0, 4000) - 2000);
               csr_write(REG_YAW_SETPOINT, ($urandom_range(0, 1) == 0) ? $urandom
                         : $urandom_range(0, 4000) - 2000);
               csr_write(REG_BASE_THROTTLE, ($urandom_range(0, 3) == 0) ? $urandom
                         : $urandom_range(1000000, 2000000));
               if ($urandom_range(0, 4) == 0) begin
                  // limits may cross here
                  csr_write(REG_MOTOR_MIN, $urandom);
                  csr_write(REG_MOTOR_MAX, $urandom);
               end else begin
                  csr_write(REG_MOTOR_MIN, $urandom_range(0, 1400000));
                  csr_write(REG_MOTOR_MAX, $urandom_range(1600000, 4194303));
               end
            end
         endcase

         for (n = 0; n < ItemsPerPhase; n++) begin
            // Twice in the run: receiver holds off while requests keep coming
            pressure = (phase == 3 || phase == 6) && n >= 10 && n < 50;
            if ((phase == 3 || phase == 6) && n == 10) hold_ask <= hold_ask + 1;
            roll_walk  = pick_angle(cfg_roll_sp, roll_walk);
            pitch_walk = pick_angle(cfg_pitch_sp, pitch_walk);
            yaw_walk   = pick_angle(cfg_yaw_sp, yaw_walk);
            sample.roll_angle  = roll_walk[AngleW-1:0];
            sample.pitch_angle = pitch_walk[AngleW-1:0];
            sample.yaw_angle   = yaw_walk[AngleW-1:0];
            send_request(sample, pressure ? 0 : pick_gap());
         end
      end

      drain_pipe();
      if (duty_expect_q.size() != 0)
         report_mismatch("requests left without response", duty_expect_q.size(), 0);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- quad_attitude_pd_mixer_core.f -----
hdl/qapm_pkg.sv
hdl/qapm_regs.sv
hdl/qapm_axis.sv
hdl/qapm_mix.sv
hdl/quad_attitude_pd_mixer_core.sv
test/quad_attitude_pd_mixer_core_tb.sv
